[src/esfe_pkg.sv]
package esfe_pkg;

	localparam logic [7:0] START_BYTE  = 8'hAA;
	localparam logic [7:0] ESC_BYTE    = 8'hAB;
	localparam logic [7:0] ESC_OF_AA   = 8'hAC;
	localparam logic [7:0] MAX_PAYLOAD = 8'd253;
	localparam logic [7:0] LEN_OVERHEAD = 8'd2;

	localparam logic KIND_BEGIN   = 1'b0;
	localparam logic KIND_PAYLOAD = 1'b1;

	localparam int BURST_MAX = 5;
	localparam int CNT_W     = $clog2(BURST_MAX + 1);
	localparam int IDX_W     = $clog2(BURST_MAX);

	typedef logic [7:0] byte_t;

	typedef struct packed {
		logic  two;
		byte_t first;
		byte_t second;
	} esc_t;

	typedef struct packed {
		logic [BURST_MAX-1:0][7:0] bytes;
		logic [CNT_W-1:0]          count;
		logic                      frame_end;
		logic                      too_long;
	} burst_t;

	function automatic esc_t escape(input byte_t b);
		esc_t e;
		e.two    = 1'b0;
		e.first  = b;
		e.second = '0;
		if (b == START_BYTE) begin
			e.two    = 1'b1;
			e.first  = ESC_BYTE;
			e.second = ESC_OF_AA;
		end else if (b == ESC_BYTE) begin
			e.two    = 1'b1;
			e.first  = ESC_BYTE;
			e.second = ESC_BYTE;
		end
		return e;
	endfunction

endpackage

[src/esfe_item_if.sv]
interface esfe_item_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] opcode;
	logic [7:0] payload_length;
	logic [7:0] data_byte;

	modport source(output valid, kind, opcode, payload_length, data_byte, input ready);
	modport sink(input valid, kind, opcode, payload_length, data_byte, output ready);
endinterface

[src/esfe_result_if.sv]
interface esfe_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       frame_end;
	logic       too_long;

	modport source(output valid, out_byte, run_last, frame_end, too_long, input ready);
	modport sink(input valid, out_byte, run_last, frame_end, too_long, output ready);
endinterface

[src/esfe_expand.sv]
module esfe_expand (
	input  logic            clk,
	input  logic            arst_n,
	esfe_item_if.sink       item,
	output esfe_pkg::burst_t burst,
	output logic            burst_vld,
	input  logic            burst_rdy
);
	import esfe_pkg::*;

	logic [7:0]       bytes_left_q;
	logic             frame_open_q;
	logic [7:0]       bytes_left_nxt;
	logic             frame_open_nxt;
	burst_t           nxt;
	logic             nxt_vld;
	logic             accept;
	esc_t             e_len;
	esc_t             e_op;
	esc_t             e_dat;
	logic [IDX_W-1:0] pos;
	logic [7:0]       left_dec;

	assign item.ready = !burst_vld || burst_rdy;
	assign accept     = item.valid && item.ready;
	assign e_len      = escape(item.payload_length + LEN_OVERHEAD);
	assign e_op       = escape(item.opcode);
	assign e_dat      = escape(item.data_byte);
	assign left_dec   = bytes_left_q - 8'd1;

	always_comb begin
		nxt            = '0;
		nxt_vld        = 1'b0;
		pos            = '0;
		bytes_left_nxt = bytes_left_q;
		frame_open_nxt = frame_open_q;
		if (item.kind == KIND_BEGIN) begin
			nxt_vld = 1'b1;
			if (item.payload_length > MAX_PAYLOAD) begin
				nxt.count      = CNT_W'(1);
				nxt.too_long   = 1'b1;
				bytes_left_nxt = '0;
				frame_open_nxt = 1'b0;
			end else begin
				nxt.bytes[0]   = START_BYTE;
				pos            = IDX_W'(1);
				nxt.bytes[pos] = e_len.first;
				pos            = pos + IDX_W'(1);
				if (e_len.two) begin
					nxt.bytes[pos] = e_len.second;
					pos            = pos + IDX_W'(1);
				end
				nxt.bytes[pos] = e_op.first;
				pos            = pos + IDX_W'(1);
				if (e_op.two) begin
					nxt.bytes[pos] = e_op.second;
					pos            = pos + IDX_W'(1);
				end
				nxt.count      = CNT_W'(pos);
				nxt.frame_end  = (item.payload_length == 8'd0);
				bytes_left_nxt = item.payload_length;
				frame_open_nxt = (item.payload_length != 8'd0);
			end
		end else if (frame_open_q) begin
			nxt_vld        = 1'b1;
			nxt.bytes[0]   = e_dat.first;
			nxt.bytes[1]   = e_dat.second;
			nxt.count      = e_dat.two ? CNT_W'(2) : CNT_W'(1);
			nxt.frame_end  = (left_dec == 8'd0);
			bytes_left_nxt = left_dec;
			frame_open_nxt = (left_dec != 8'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= '0;
			frame_open_q <= 1'b0;
			burst_vld    <= 1'b0;
		end else begin
			if (accept) begin
				bytes_left_q <= bytes_left_nxt;
				frame_open_q <= frame_open_nxt;
				burst_vld    <= nxt_vld;
			end else if (burst_rdy) begin
				burst_vld <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			burst <= nxt;
		end
	end

endmodule

[src/esfe_serial.sv]
module esfe_serial (
	input  logic             clk,
	input  logic             arst_n,
	input  esfe_pkg::burst_t burst,
	input  logic             burst_vld,
	output logic             burst_rdy,
	esfe_result_if.source    result
);
	import esfe_pkg::*;

	burst_t           cur_q;
	logic             cur_vld_q;
	logic [IDX_W-1:0] idx_q;
	logic             last;
	logic             take;

	assign last      = (CNT_W'(idx_q) == cur_q.count - CNT_W'(1));
	assign burst_rdy = !cur_vld_q || (result.ready && last);
	assign take      = burst_vld && burst_rdy;

	assign result.valid     = cur_vld_q;
	assign result.out_byte  = cur_q.bytes[idx_q];
	assign result.run_last  = last;
	assign result.frame_end = last && cur_q.frame_end;
	assign result.too_long  = cur_q.too_long;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_vld_q <= 1'b0;
			idx_q     <= '0;
		end else begin
			if (take) begin
				cur_vld_q <= 1'b1;
				idx_q     <= '0;
			end else if (cur_vld_q && result.ready) begin
				if (last) begin
					cur_vld_q <= 1'b0;
				end else begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cur_q <= burst;
		end
	end

endmodule

[src/escaped_serial_frame_encoder.sv]
// Serial frame encoder with byte stuffing. A begin item (kind 0) sends the start byte 0xAA,
// then the escaped length byte (payload_length + 2) and the escaped opcode; each payload
// item (kind 1) sends its escaped data byte. 0xAA goes out as AB AC and 0xAB as AB AB.
// A begin with more than 253 payload bytes gives one result with too_long set and closes
// any open frame; payload items with no frame open are dropped without a result.
// One byte leaves per cycle while result.ready is high; an item gives one to five output bytes
// (one or two for payload items, none for a dropped one), and the output stage is the limit. Items
// are taken every cycle while the output stage can take the held expanded item, with one expanded
// item held between the input and output stages.
module escaped_serial_frame_encoder (
	input  logic          clk,
	input  logic          arst_n,
	esfe_item_if.sink     item,
	esfe_result_if.source result
);
	import esfe_pkg::*;

	burst_t burst;
	logic   burst_vld;
	logic   burst_rdy;

	esfe_expand u_expand (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.burst     (burst),
		.burst_vld (burst_vld),
		.burst_rdy (burst_rdy)
	);

	esfe_serial u_serial (
		.clk       (clk),
		.arst_n    (arst_n),
		.burst     (burst),
		.burst_vld (burst_vld),
		.burst_rdy (burst_rdy),
		.result    (result)
	);

endmodule
